FILE: hdl/tzc_pkg.sv
// types, codes and constants shared by the triac zero-cross gate control block
// no dependencies

package tzc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_MIN_EDGE    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_EDGE    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DIM_MODE    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PERCENT     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BURST_COUNT = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PHASE_DELAY = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_GATE_PULSE  = 3'd6;

	// register reset values
	localparam logic [15:0] MIN_EDGE_RST    = 16'd500;
	localparam logic [15:0] MAX_EDGE_RST    = 16'd3000;
	localparam logic [1:0]  DIM_MODE_RST    = 2'd2;
	localparam logic [6:0]  PERCENT_RST     = 7'd0;
	localparam logic [7:0]  BURST_COUNT_RST = 8'd100;
	localparam logic [15:0] PHASE_DELAY_RST = 16'd0;
	localparam logic [15:0] GATE_PULSE_RST  = 16'd100;

	// dim modes
	localparam logic [1:0] DIM_BURST = 2'd0;
	localparam logic [1:0] DIM_PHASE = 2'd1;

	// opcodes
	localparam logic OP_EDGE   = 1'b0;
	localparam logic OP_EXPIRE = 1'b1;

	localparam logic [15:0] PERIOD_SAT = 16'hFFFF;
	localparam logic [14:0] PCT_SCALE  = 15'd100;

	typedef struct packed {
		logic        opcode;
		logic [31:0] timestamp_us;
	} in_t;

	typedef struct packed {
		logic        gate_level;
		logic        timer_start;
		logic [15:0] timer_delay_us;
		logic [15:0] period_us;
		logic [15:0] window_us;
	} out_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_COMMIT
	} state_t;

endpackage

FILE: hdl/triac_zero_cross_gate_control.sv
// triac zero-cross gate control: phase angle and burst firing from detector edges
// an item is latched, timed, then committed; the next is taken only after commit
// throughput limited by the load, timing and commit steps of the controller
// a waiting result holds the commit step until it is transferred
// arst_n clears all timing state and loads the register defaults
// depends on tzc_pkg, tzc_ctrl, tzc_dp

module triac_zero_cross_gate_control (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tzc_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tzc_pkg::out_t                out_data,
	input  logic                         cfg_we,
	input  logic [tzc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tzc_pkg::CfgDataW-1:0] cfg_data
);

	tzc_pkg::cmd_t cmd;

	tzc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tzc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data)
	);

endmodule

FILE: hdl/tzc_dp.sv
// datapath: configuration registers, edge timing state, burst counter and result register
// depends on tzc_pkg

module tzc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tzc_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  logic [tzc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [tzc_pkg::CfgDataW-1:0] cfg_data,
	input  tzc_pkg::in_t                in_data,
	output tzc_pkg::out_t               out_data
);

	// configuration
	logic [15:0] min_edge_q, max_edge_q, phase_delay_q, gate_pulse_q;
	logic [1:0]  dim_mode_q;
	logic [6:0]  percent_q;
	logic [7:0]  burst_count_q;

	// block state
	logic [31:0] last_edge_q, last_period_q;
	logic [15:0] period_q, window_q;
	logic [7:0]  burst_cnt_q;
	logic        armed_q, gate_q;

	// latched item
	logic        op_q;
	logic [31:0] ts_q;

	// timing stage
	logic        lt_min_s1, lt_max_s1, wide_s1, cnt_ge_s1;
	logic [15:0] width_s1, period_s1;
	logic [7:0]  cnt_inc_s1;
	logic [14:0] prod_a_s1, prod_b_s1;

	logic [31:0] width_c, pspan_c;
	logic [7:0]  cnt_inc_c;

	// commit results
	logic [31:0] last_edge_d, last_period_d;
	logic [15:0] period_d, window_d, delay_d;
	logic [7:0]  burst_cnt_d;
	logic        armed_d, gate_d, start_d;

	tzc_pkg::out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_edge_q    <= tzc_pkg::MIN_EDGE_RST;
			max_edge_q    <= tzc_pkg::MAX_EDGE_RST;
			dim_mode_q    <= tzc_pkg::DIM_MODE_RST;
			percent_q     <= tzc_pkg::PERCENT_RST;
			burst_count_q <= tzc_pkg::BURST_COUNT_RST;
			phase_delay_q <= tzc_pkg::PHASE_DELAY_RST;
			gate_pulse_q  <= tzc_pkg::GATE_PULSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tzc_pkg::REG_MIN_EDGE:    min_edge_q <= cfg_data;
				tzc_pkg::REG_MAX_EDGE:    max_edge_q <= cfg_data;
				tzc_pkg::REG_DIM_MODE:    dim_mode_q <= cfg_data[1:0];
				tzc_pkg::REG_PERCENT:     percent_q <= cfg_data[6:0];
				tzc_pkg::REG_BURST_COUNT: begin
					burst_count_q <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
				end
				tzc_pkg::REG_PHASE_DELAY: phase_delay_q <= cfg_data;
				tzc_pkg::REG_GATE_PULSE:  gate_pulse_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data.opcode;
			ts_q <= in_data.timestamp_us;
		end
	end

	assign width_c   = ts_q - last_edge_q;
	assign pspan_c   = ts_q - last_period_q;
	assign cnt_inc_c = burst_cnt_q + 8'd1;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			lt_min_s1  <= width_c < {16'd0, min_edge_q};
			lt_max_s1  <= width_c < {16'd0, max_edge_q};
			wide_s1    <= |width_c[31:16];
			width_s1   <= width_c[15:0];
			period_s1  <= (|pspan_c[31:16]) ? tzc_pkg::PERIOD_SAT : pspan_c[15:0];
			cnt_inc_s1 <= cnt_inc_c;
			cnt_ge_s1  <= cnt_inc_c >= burst_count_q;
			// floor(c*100/n) <= p  is the same as  c*100 < (p+1)*n
			prod_a_s1  <= 15'({7'd0, cnt_inc_c} * tzc_pkg::PCT_SCALE);
			prod_b_s1  <= 15'(({8'd0, percent_q} + 15'd1) * {7'd0, burst_count_q});
		end
	end

	always_comb begin
		last_edge_d   = last_edge_q;
		last_period_d = last_period_q;
		period_d      = period_q;
		window_d      = window_q;
		burst_cnt_d   = burst_cnt_q;
		armed_d       = armed_q;
		gate_d        = gate_q;
		start_d       = 1'b0;
		delay_d       = 16'd0;
		if (op_q == tzc_pkg::OP_EXPIRE) begin
			if (armed_q) begin
				gate_d  = 1'b1;
				armed_d = 1'b0;
				start_d = 1'b1;
				delay_d = gate_pulse_q;
			end else begin
				gate_d = 1'b0;
			end
		end else if (!lt_min_s1) begin
			last_edge_d = ts_q;
			if (wide_s1) begin
				period_d = tzc_pkg::PERIOD_SAT;
			end else if (lt_max_s1) begin
				window_d = width_s1;
			end else begin
				period_d      = period_s1;
				last_period_d = ts_q;
				if (dim_mode_q == tzc_pkg::DIM_BURST) begin
					if (percent_q == 7'd0) begin
						gate_d = 1'b0;
					end else begin
						burst_cnt_d = cnt_ge_s1 ? 8'd0 : cnt_inc_s1;
						if (prod_a_s1 < prod_b_s1) begin
							armed_d = 1'b1;
							start_d = 1'b1;
							delay_d = phase_delay_q;
						end else begin
							gate_d = 1'b0;
						end
					end
				end else if (dim_mode_q == tzc_pkg::DIM_PHASE) begin
					gate_d = 1'b0;
					if (phase_delay_q != 16'd0) begin
						armed_d = 1'b1;
						start_d = 1'b1;
						delay_d = phase_delay_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q   <= 32'd0;
			last_period_q <= 32'd0;
			period_q      <= 16'd0;
			window_q      <= 16'd0;
			burst_cnt_q   <= 8'd0;
			armed_q       <= 1'b0;
			gate_q        <= 1'b0;
		end else if (cmd.commit) begin
			last_edge_q   <= last_edge_d;
			last_period_q <= last_period_d;
			period_q      <= period_d;
			window_q      <= window_d;
			burst_cnt_q   <= burst_cnt_d;
			armed_q       <= armed_d;
			gate_q        <= gate_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.gate_level     <= gate_d;
			out_q.timer_start    <= start_d;
			out_q.timer_delay_us <= delay_d;
			out_q.period_us      <= period_d;
			out_q.window_us      <= window_d;
		end
	end

	assign out_data = out_q;

endmodule

FILE: hdl/tzc_ctrl.sv
// controller: item sequencing and output valid handling
// depends on tzc_pkg

module tzc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output tzc_pkg::cmd_t cmd
);

	tzc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tzc_pkg::ST_IDLE:   if (in_valid) state_d = tzc_pkg::ST_CALC;
			tzc_pkg::ST_CALC:   state_d = tzc_pkg::ST_COMMIT;
			tzc_pkg::ST_COMMIT: if (out_free) state_d = tzc_pkg::ST_IDLE;
			default:            state_d = tzc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.calc   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			tzc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			tzc_pkg::ST_CALC:   cmd.calc = 1'b1;
			tzc_pkg::ST_COMMIT: cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tzc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.calc, cmd.commit}))
		else $error("more than one datapath command");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not raise out_valid");

	a_calc_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |=> state_q == tzc_pkg::ST_COMMIT)
		else $error("calc not followed by commit state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.commit)
		else $error("result overwritten while stalled");

	a_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.calc)
		else $error("accepted item not processed");

endmodule

FILE: dv/triac_zero_cross_gate_control_tb.sv
`timescale 1ns / 1ps

// self-checking testbench for triac_zero_cross_gate_control: directed and random detector
// edge and gate timer transfers, each result checked against an in-bench model of the gate logic
// depends on tzc_pkg and triac_zero_cross_gate_control

module triac_zero_cross_gate_control_tb;

	localparam logic [tzc_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;
	localparam logic [1:0] DIM_OFF = 2'd2;
	localparam logic [1:0] DIM_SPARE = 2'd3;
	localparam int IDLE_PCT = 13;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS = 135;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tzc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tzc_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [tzc_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [tzc_pkg::CfgDataW-1:0] cfg_data = '0;

	// register copies
	logic [15:0] min_edge = tzc_pkg::MIN_EDGE_RST;
	logic [15:0] max_edge = tzc_pkg::MAX_EDGE_RST;
	logic [1:0] dim_sel = tzc_pkg::DIM_MODE_RST;
	logic [6:0] power_pct = tzc_pkg::PERCENT_RST;
	logic [7:0] burst_len = tzc_pkg::BURST_COUNT_RST;
	logic [15:0] fire_delay = tzc_pkg::PHASE_DELAY_RST;
	logic [15:0] pulse_len = tzc_pkg::GATE_PULSE_RST;

	// timing and firing state
	logic [31:0] last_edge_ts = '0;
	logic [31:0] last_period_ts = '0;
	logic [15:0] period_meas = '0;
	logic [15:0] window_meas = '0;
	logic [7:0] burst_cnt = '0;
	logic armed = 1'b0;
	logic gate_on = 1'b0;

	tzc_pkg::out_t gate_results_q[$];
	tzc_pkg::out_t want_result;
	bit idle_on = 1'b1;
	int stall_hold = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 0;

	triac_zero_cross_gate_control DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic tzc_pkg::out_t apply_gate_event(tzc_pkg::in_t ev);
		tzc_pkg::out_t r;
		logic [31:0] span;
		logic [31:0] since_period;
		logic is_long;
		logic fire;
		r = '0;
		fire = 1'b0;
		if (ev.opcode == tzc_pkg::OP_EXPIRE) begin
			if (armed) begin
				gate_on = 1'b1;
				armed = 1'b0;
				r.timer_start = 1'b1;
				r.timer_delay_us = pulse_len;
			end else
				gate_on = 1'b0;
		end else begin
			span = ev.timestamp_us - last_edge_ts;
			if (span >= 32'(min_edge)) begin
				is_long = span >= 32'(max_edge);
				last_edge_ts = ev.timestamp_us;
				if (span > 32'(tzc_pkg::PERIOD_SAT))
					period_meas = tzc_pkg::PERIOD_SAT;
				else if (!is_long)
					window_meas = span[15:0];
				else begin
					since_period = ev.timestamp_us - last_period_ts;
					period_meas = (since_period > 32'(tzc_pkg::PERIOD_SAT))
						? tzc_pkg::PERIOD_SAT : since_period[15:0];
					last_period_ts = ev.timestamp_us;
					if (dim_sel == tzc_pkg::DIM_BURST) begin
						if (power_pct == 0)
							gate_on = 1'b0;
						else begin
							burst_cnt = burst_cnt + 8'd1;
							if ((int'(burst_cnt) * int'(tzc_pkg::PCT_SCALE))
									/ int'(burst_len) <= int'(power_pct))
								fire = 1'b1;
							else
								gate_on = 1'b0;
							if (burst_cnt >= burst_len)
								burst_cnt = '0;
						end
					end else if (dim_sel == tzc_pkg::DIM_PHASE) begin
						gate_on = 1'b0;
						fire = fire_delay != 0;
					end
				end
			end
		end
		if (fire) begin
			armed = 1'b1;
			r.timer_start = 1'b1;
			r.timer_delay_us = fire_delay;
		end
		r.gate_level = gate_on;
		r.period_us = period_meas;
		r.window_us = window_meas;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (gate_results_q.size() == 0) begin
				$error("result transfer with no expectation waiting");
				mismatches++;
			end else begin
				want_result = gate_results_q.pop_front();
				check_field("gate_level", 16'(want_result.gate_level), 16'(out_data.gate_level));
				check_field("timer_start", 16'(want_result.timer_start),
					16'(out_data.timer_start));
				check_field("timer_delay_us", want_result.timer_delay_us,
					out_data.timer_delay_us);
				check_field("period_us", want_result.period_us, out_data.period_us);
				check_field("window_us", want_result.window_us, out_data.window_us);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold = stall_hold - 1;
		end else
			out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(tzc_pkg::in_t item);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gate_results_q.push_back(apply_gate_event(item));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_edge(logic [31:0] span);
		tzc_pkg::in_t item;
		item.opcode = tzc_pkg::OP_EDGE;
		item.timestamp_us = last_edge_ts + span;
		send_item(item);
	endtask

	task automatic send_expiry();
		tzc_pkg::in_t item;
		item.opcode = tzc_pkg::OP_EXPIRE;
		item.timestamp_us = $urandom;
		send_item(item);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (gate_results_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [tzc_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			tzc_pkg::REG_MIN_EDGE: min_edge = val;
			tzc_pkg::REG_MAX_EDGE: max_edge = val;
			tzc_pkg::REG_DIM_MODE: dim_sel = val[1:0];
			tzc_pkg::REG_PERCENT: power_pct = val[6:0];
			tzc_pkg::REG_BURST_COUNT: burst_len = (val[7:0] == 0) ? 8'd1 : val[7:0];
			tzc_pkg::REG_PHASE_DELAY: fire_delay = val;
			tzc_pkg::REG_GATE_PULSE: pulse_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// optional noise and window edges, a period edge, up to two timer expiries, then optional junk
	task automatic send_mains_cycle();
		int unsigned long_lo;
		tzc_pkg::in_t junk;
		long_lo = 32'((max_edge > min_edge) ? max_edge : min_edge);
		if (min_edge != 0 && $urandom_range(99) < 15)
			send_edge($urandom_range(min_edge - 1, 0));
		if (max_edge > min_edge && $urandom_range(99) < 90)
			send_edge($urandom_range(max_edge - 1, min_edge));
		if ($urandom_range(99) < 5)
			send_edge($urandom_range(32'hFFFFFFFF, 32'h10000));
		else
			send_edge($urandom_range(long_lo + 20000, long_lo));
		if ($urandom_range(99) < 85)
			send_expiry();
		if ($urandom_range(99) < 80)
			send_expiry();
		if ($urandom_range(99) < 10) begin
			junk.opcode = 1'($urandom_range(1, 0));
			junk.timestamp_us = $urandom;
			send_item(junk);
		end
	endtask

	task automatic run_phase(int unsigned lo, int unsigned hi, int unsigned mode,
			int unsigned pct, int unsigned cnt, int unsigned dly, int unsigned pulse);
		int start_count;
		drain_results();
		write_reg(tzc_pkg::REG_MIN_EDGE, 16'(lo));
		write_reg(tzc_pkg::REG_MAX_EDGE, 16'(hi));
		write_reg(tzc_pkg::REG_DIM_MODE, 16'(mode));
		write_reg(tzc_pkg::REG_PERCENT, 16'(pct));
		write_reg(tzc_pkg::REG_BURST_COUNT, 16'(cnt));
		write_reg(tzc_pkg::REG_PHASE_DELAY, 16'(dly));
		write_reg(tzc_pkg::REG_GATE_PULSE, 16'(pulse));
		write_reg(REG_NONE, 16'($urandom));
		settings_used++;
		start_count = items_sent;
		while (items_sent - start_count < PHASE_ITEMS) send_mains_cycle();
	endtask

	task automatic test_default_config();
		send_edge(32'd100);
		send_edge(32'd1000);
		send_edge(32'd10000);
		send_edge(32'd70000);
		send_expiry();
	endtask

	task automatic test_phase_firing();
		drain_results();
		write_reg(tzc_pkg::REG_DIM_MODE, 16'(tzc_pkg::DIM_PHASE));
		write_reg(tzc_pkg::REG_PHASE_DELAY, 16'd2000);
		write_reg(tzc_pkg::REG_GATE_PULSE, 16'hFFFF);
		write_reg(tzc_pkg::REG_MAX_EDGE, 16'd60000);
		settings_used++;
		send_edge(32'd1000);
		send_edge(32'd60000);
		send_expiry();
		send_expiry();
		// period edge more than the saturation limit after the previous one
		send_edge(32'd50000);
		send_edge(32'd60000);
		send_expiry();
		send_expiry();
		drain_results();
		write_reg(tzc_pkg::REG_PHASE_DELAY, 16'd0);
		send_edge(32'd60000);
		send_expiry();
	endtask

	task automatic test_burst_firing();
		drain_results();
		write_reg(tzc_pkg::REG_MAX_EDGE, 16'd3000);
		write_reg(tzc_pkg::REG_DIM_MODE, 16'(tzc_pkg::DIM_BURST));
		write_reg(tzc_pkg::REG_PERCENT, 16'd0);
		settings_used++;
		send_edge(32'd5000);
		drain_results();
		write_reg(tzc_pkg::REG_PERCENT, 16'd100);
		write_reg(tzc_pkg::REG_BURST_COUNT, 16'd0);
		write_reg(REG_NONE, 16'hFFFF);
		send_edge(32'd5000);
		send_expiry();
	endtask

	task automatic test_timestamp_wrap();
		tzc_pkg::in_t item;
		item.opcode = tzc_pkg::OP_EDGE;
		item.timestamp_us = 32'hFFFFFE00;
		send_item(item);
		send_edge(32'h1000);
		item.opcode = tzc_pkg::OP_EXPIRE;
		item.timestamp_us = 32'h0;
		send_item(item);
		item.timestamp_us = 32'hFFFFFFFF;
		send_item(item);
	endtask

	task automatic test_random_settings();
		run_phase(500, 3000, tzc_pkg::DIM_PHASE, 0, 100, 2500, 100);
		run_phase(500, 3000, tzc_pkg::DIM_BURST, 37, 10, 1200, 300);
		run_phase(500, 3000, tzc_pkg::DIM_BURST, 100, 255, 0, 65535);
		idle_on = 1'b0;
		run_phase(0, 0, tzc_pkg::DIM_PHASE, 100, 1, 65535, 0);
		idle_on = 1'b1;
		run_phase(65535, 65535, tzc_pkg::DIM_BURST, 1, 1, 1, 1);
		run_phase(1000, 800, DIM_SPARE, 50, 7, 300, 40);
		run_phase(200, 65535, DIM_OFF, 20, 3, 900, 50);
		run_phase(500, 3000, tzc_pkg::DIM_BURST, 50, 0, 0, 100);
		repeat (4)
			run_phase($urandom_range(2000, 0), $urandom_range(8000, 0), $urandom_range(3, 0),
				$urandom_range(100, 0), $urandom_range(255, 0), $urandom_range(65535, 0),
				$urandom_range(65535, 0));
	endtask

	// receiver holds off while the sender keeps offering transfers
	task automatic test_output_backpressure();
		drain_results();
		write_reg(tzc_pkg::REG_MIN_EDGE, tzc_pkg::MIN_EDGE_RST);
		write_reg(tzc_pkg::REG_MAX_EDGE, tzc_pkg::MAX_EDGE_RST);
		write_reg(tzc_pkg::REG_DIM_MODE, 16'(tzc_pkg::DIM_PHASE));
		write_reg(tzc_pkg::REG_PHASE_DELAY, 16'd1500);
		settings_used++;
		idle_on = 1'b0;
		@(posedge clk);
		stall_hold = HOLD_CYCLES;
		@(negedge clk);
		repeat (12) send_mains_cycle();
		drain_results();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_config();
		test_phase_firing();
		test_burst_firing();
		test_timestamp_wrap();
		test_random_settings();
		test_output_backpressure();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d input transfers and %0d result transfers", items_sent,
			results_seen);
		$display("across %0d register settings, with a long output hold-off", settings_used);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
hdl/tzc_pkg.sv
hdl/tzc_dp.sv
hdl/tzc_ctrl.sv
hdl/triac_zero_cross_gate_control.sv
dv/triac_zero_cross_gate_control_tb.sv
